/* sv/tlvrs_pkg.sv */
// Shared types and constants for the TLV record store.
// Holds the command and result beat layouts plus operation and status codes.
// No dependencies.
package tlvrs_pkg;

    // Operation codes carried by a command beat.
    localparam logic [2:0] OP_FIND     = 3'd0;
    localparam logic [2:0] OP_WR_START = 3'd1;
    localparam logic [2:0] OP_WR_DATA  = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_DELETE   = 3'd4;

    // Status codes carried by a result beat.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_NO_SPACE  = 2'd2;
    localparam logic [1:0] STAT_BAD       = 2'd3;

    // One command beat as latched from the input channel.
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] tag;
        logic [7:0] length;
        logic [9:0] position;
        logic       use_position;
        logic [7:0] data_byte;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [1:0] status;
        logic [9:0] record_offset;
        logic [7:0] record_length;
        logic [9:0] next_offset;
        logic       next_valid;
        logic [7:0] read_data;
    } t_result;

    // Builds a result beat from its fields.
    function automatic t_result mk_res(
        input logic [1:0] status,
        input logic [9:0] record_offset,
        input logic [7:0] record_length,
        input logic [9:0] next_offset,
        input logic       next_valid,
        input logic [7:0] read_data
    );
        t_result r;
        r.status        = status;
        r.record_offset = record_offset;
        r.record_length = record_length;
        r.next_offset   = next_offset;
        r.next_valid    = next_valid;
        r.read_data     = read_data;
        return r;
    endfunction

endpackage

/* sv/tlv_record_store_top.sv */
// TLV record store: tag, length and value records packed in a byte arena
// memory. A find walks records from offset 0 or a given position; a write
// start reserves room for a record, and each following write data beat stores
// one payload byte; a read byte returns one arena byte; a delete removes the
// record at a position by moving the rest of the arena down and zero-filling
// the tail. Each command beat yields exactly one result beat. After reset the
// arena is zeroed before the first command is taken. One command is in work at
// a time; a finished result waits in the output register so the next command
// can be taken meanwhile.
// Depends on tlvrs_pkg, tlvrs_engine and tlvrs_ram.
module tlv_record_store_top
    import tlvrs_pkg::*;
#(
    parameter int ARENA_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_tag,
    input  logic [7:0] i_length,
    input  logic [9:0] i_position,
    input  logic       i_use_position,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [9:0] o_record_offset,
    output logic [7:0] o_record_length,
    output logic [9:0] o_next_offset,
    output logic       o_next_valid,
    output logic [7:0] o_read_data
);

    localparam int AW = $clog2(ARENA_BYTES);

    t_cmd          w_cmd;
    t_result       w_res;
    logic          w_res_valid;
    logic          w_res_ready;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_raddr;
    logic [7:0]    w_mem_rdata;
    logic          r_out_valid, n_out_valid;
    t_result       r_out;

    // Gather the command beat.
    always_comb begin
        w_cmd.operation    = i_operation;
        w_cmd.tag          = i_tag;
        w_cmd.length       = i_length;
        w_cmd.position     = i_position;
        w_cmd.use_position = i_use_position;
        w_cmd.data_byte    = i_data_byte;
    end

    tlvrs_engine #(
        .ARENA_BYTES (ARENA_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .o_cmd_ready (o_in_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    tlvrs_ram #(
        .DEPTH (ARENA_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Output register: loads when empty or when its beat leaves this cycle.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_record_offset = r_out.record_offset;
    assign o_record_length = r_out.record_length;
    assign o_next_offset   = r_out.next_offset;
    assign o_next_valid    = r_out.next_valid;
    assign o_read_data     = r_out.read_data;

endmodule

/* sv/tlvrs_ram.sv */
// Byte-wide arena memory of the TLV record store.
// One write port and one read port; read data is registered.
// No package dependencies.
module tlvrs_ram #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tlvrs_engine.sv */
// Operation sequencer of the TLV record store: clearing pass, record walk,
// header and payload writes, byte read and delete shift over the arena memory.
// Depends on tlvrs_pkg; drives the ports of tlvrs_ram.
module tlvrs_engine
    import tlvrs_pkg::*;
#(
    parameter int ARENA_BYTES = 1024,
    localparam int AW = $clog2(ARENA_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  t_cmd          i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [7:0]    o_mem_wdata,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [7:0]    i_mem_rdata
);

    // Offset width: holds any arena offset plus a full record (2 + 255).
    localparam int CW = ((AW > 9) ? AW : 9) + 2;
    localparam logic [CW-1:0] AB_C = CW'(ARENA_BYTES);
    localparam logic [CW-1:0] TWO  = CW'(2);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [12:0] {
        ST_CLEAR     = 13'b0000000000001,
        ST_IDLE      = 13'b0000000000010,
        ST_EXEC      = 13'b0000000000100,
        ST_WALK_T    = 13'b0000000001000,
        ST_WALK_L    = 13'b0000000010000,
        ST_WALK_C    = 13'b0000000100000,
        ST_WR_FIT    = 13'b0000001000000,
        ST_WR_TAG    = 13'b0000010000000,
        ST_WR_LEN    = 13'b0000100000000,
        ST_READ      = 13'b0001000000000,
        ST_DEL_LEN   = 13'b0010000000000,
        ST_DEL_SHIFT = 13'b0100000000000,
        ST_EMIT      = 13'b1000000000000
    } t_state;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    t_result         r_res, n_res;
    logic [CW-1:0]   r_cur, n_cur;
    logic            r_hit, n_hit;
    logic            r_rd_oor, n_rd_oor;
    logic [CW-1:0]   r_src, n_src;
    logic [CW-1:0]   r_dst, n_dst;
    logic            r_wv, n_wv;
    logic            r_woor, n_woor;
    logic [AW-1:0]   r_wdst, n_wdst;
    logic [7:0]      r_rl, n_rl;
    logic [CW-1:0]   r_pay_ptr, n_pay_ptr;
    logic [7:0]      r_pay_rem, n_pay_rem;

    // Helper values derived from the registers.
    logic [7:0]    w_rbyte;
    logic [7:0]    w_walk_tag;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_pos1;
    logic [CW-1:0] w_cur1;
    logic [CW-1:0] w_next;
    logic [CW-1:0] w_fit;
    logic [CW-1:0] w_ptr1;
    logic [7:0]    w_rem1;
    logic [1:0]    w_miss;

    // Bytes fetched from beyond the arena read as zero.
    assign w_rbyte    = r_rd_oor ? 8'd0 : i_mem_rdata;
    // A write start without position walks for the first empty place.
    assign w_walk_tag = (r_cmd.operation == OP_FIND) ? r_cmd.tag : 8'd0;
    assign w_pos      = CW'(r_cmd.position);
    assign w_pos1     = w_pos + ONE;
    assign w_cur1     = r_cur + ONE;
    assign w_next     = r_cur + TWO + CW'(w_rbyte);
    assign w_fit      = r_cur + TWO + CW'(r_cmd.length);
    assign w_ptr1     = r_pay_ptr + ONE;
    assign w_rem1     = r_pay_rem - 8'd1;
    assign w_miss     = (r_cmd.operation == OP_FIND) ? STAT_NOT_FOUND : STAT_NO_SPACE;

    // Next-state and memory port logic.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_cur     = r_cur;
        n_hit     = r_hit;
        n_rd_oor  = r_rd_oor;
        n_src     = r_src;
        n_dst     = r_dst;
        n_wv      = r_wv;
        n_woor    = r_woor;
        n_wdst    = r_wdst;
        n_rl      = r_rl;
        n_pay_ptr = r_pay_ptr;
        n_pay_rem = r_pay_rem;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_dst[AW-1:0];
        o_mem_wdata = 8'd0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cur[AW-1:0];

        case (r_state)
            // Zero the arena one byte per cycle after reset.
            ST_CLEAR: begin
                o_mem_we = 1'b1;
                n_dst    = r_dst + ONE;
                if (r_dst == AB_C - ONE) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_state = ST_EXEC;
                end
            end

            // Decode the latched command; rejected commands report bad status.
            ST_EXEC: begin
                n_res   = mk_res(STAT_BAD, 10'd0, 8'd0, 10'd0, 1'b0, 8'd0);
                n_state = ST_EMIT;
                case (r_cmd.operation)
                    OP_FIND: begin
                        n_cur   = (r_cmd.use_position && (w_pos < AB_C)) ? w_pos : '0;
                        n_state = ST_WALK_T;
                    end
                    OP_WR_START: begin
                        if (r_cmd.use_position) begin
                            if (w_pos < AB_C) begin
                                n_cur   = w_pos;
                                n_state = ST_WR_FIT;
                            end
                        end else begin
                            n_cur   = '0;
                            n_state = ST_WALK_T;
                        end
                    end
                    OP_WR_DATA: begin
                        if ((r_pay_rem != 8'd0) && (r_pay_ptr < AB_C)) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_pay_ptr[AW-1:0];
                            o_mem_wdata = r_cmd.data_byte;
                            n_pay_ptr   = w_ptr1;
                            n_pay_rem   = w_rem1;
                            n_res       = mk_res(STAT_OK, r_pay_ptr[9:0], w_rem1,
                                                 w_ptr1[9:0], w_ptr1 < AB_C, 8'd0);
                        end
                    end
                    OP_READ: begin
                        if (w_pos < AB_C) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = w_pos[AW-1:0];
                            n_state     = ST_READ;
                        end
                    end
                    OP_DELETE: begin
                        if (w_pos < AB_C) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = w_pos1[AW-1:0];
                            n_rd_oor    = (w_pos1 >= AB_C);
                            n_state     = ST_DEL_LEN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_READ: begin
                n_res   = mk_res(STAT_OK, r_cmd.position, 8'd0, 10'd0, 1'b0, i_mem_rdata);
                n_state = ST_EMIT;
            end

            // Walk: fetch the tag byte of the record at the cursor.
            ST_WALK_T: begin
                if (r_cur >= AB_C) begin
                    n_res   = mk_res(w_miss, 10'd0, 8'd0, 10'd0, 1'b0, 8'd0);
                    n_state = ST_EMIT;
                end else begin
                    o_mem_re = 1'b1;
                    n_rd_oor = 1'b0;
                    n_state  = ST_WALK_L;
                end
            end

            // Walk: compare the tag and fetch the length byte.
            ST_WALK_L: begin
                n_hit       = (i_mem_rdata == w_walk_tag);
                o_mem_re    = 1'b1;
                o_mem_raddr = w_cur1[AW-1:0];
                n_rd_oor    = (w_cur1 >= AB_C);
                n_state     = ST_WALK_C;
            end

            // Walk: on a hit report it or check the fit; else step over the record, or miss past the end.
            ST_WALK_C: begin
                if (r_hit) begin
                    if (r_cmd.operation == OP_FIND) begin
                        if (r_cmd.tag == 8'd0) begin
                            n_res = mk_res(STAT_OK, r_cur[9:0], 8'd0, r_cur[9:0], 1'b1, 8'd0);
                        end else begin
                            n_res = mk_res(STAT_OK, r_cur[9:0], w_rbyte, w_next[9:0],
                                           w_next < AB_C, 8'd0);
                        end
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_WR_FIT;
                    end
                end else if (w_next > AB_C) begin
                    n_res   = mk_res(w_miss, 10'd0, 8'd0, 10'd0, 1'b0, 8'd0);
                    n_state = ST_EMIT;
                end else begin
                    n_cur   = w_next;
                    n_state = ST_WALK_T;
                end
            end

            // The new record, header included, must end inside the arena.
            ST_WR_FIT: begin
                if (w_fit > AB_C) begin
                    n_res   = mk_res(STAT_NO_SPACE, 10'd0, 8'd0, 10'd0, 1'b0, 8'd0);
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_WR_TAG;
                end
            end

            ST_WR_TAG: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cur[AW-1:0];
                o_mem_wdata = r_cmd.tag;
                n_state     = ST_WR_LEN;
            end

            // Write the length byte and arm the payload pointer.
            ST_WR_LEN: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_cur1[AW-1:0];
                o_mem_wdata = r_cmd.length;
                n_pay_ptr   = r_cur + TWO;
                n_pay_rem   = r_cmd.length;
                n_res       = mk_res(STAT_OK, r_cur[9:0], r_cmd.length, w_fit[9:0],
                                     w_fit < AB_C, 8'd0);
                n_state     = ST_EMIT;
            end

            // Delete: the stored length sets the shift distance.
            ST_DEL_LEN: begin
                n_rl    = w_rbyte;
                n_src   = w_pos + TWO + CW'(w_rbyte);
                n_dst   = w_pos;
                n_wv    = 1'b0;
                n_state = ST_DEL_SHIFT;
            end

            // Delete: read source ahead, write the byte fetched last cycle down.
            ST_DEL_SHIFT: begin
                if (r_wv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wdst;
                    o_mem_wdata = r_woor ? 8'd0 : i_mem_rdata;
                end
                if (r_dst < AB_C) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_src[AW-1:0];
                    n_woor      = (r_src >= AB_C);
                    n_wdst      = r_dst[AW-1:0];
                    n_wv        = 1'b1;
                    n_dst       = r_dst + ONE;
                    n_src       = r_src + ONE;
                end else begin
                    n_wv = 1'b0;
                    if (!r_wv) begin
                        n_res   = mk_res(STAT_OK, r_cmd.position, r_rl, 10'd0, 1'b0, 8'd0);
                        n_state = ST_EMIT;
                    end
                end
            end

            ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_dst     <= '0;
            r_wv      <= 1'b0;
            r_pay_ptr <= '0;
            r_pay_rem <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_dst     <= n_dst;
            r_wv      <= n_wv;
            r_pay_ptr <= n_pay_ptr;
            r_pay_rem <= n_pay_rem;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_res    <= n_res;
        r_cur    <= n_cur;
        r_hit    <= n_hit;
        r_rd_oor <= n_rd_oor;
        r_src    <= n_src;
        r_woor   <= n_woor;
        r_wdst   <= n_wdst;
        r_rl     <= n_rl;
    end

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_EMIT);
    assign o_res       = r_res;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for tlv_record_store_top: directed and random command beats
// checked against an in-bench model of the record arena.
// Depends on tlvrs_pkg and the record store RTL.
`timescale 1ns / 100ps

module tb
    import tlvrs_pkg::*;
();

    localparam int unsigned ARENA = 1024;
    localparam int unsigned ITEMS_TOTAL = 580;

    // Tracks the arena contents and the open payload, and holds the result beats
    // still owed by the block, oldest first.
    class record_store_scoreboard;
        localparam int unsigned ARENA_SIZE = 1024;

        bit [7:0]    arena [ARENA_SIZE];
        int unsigned wr_ptr;
        int unsigned wr_left;
        t_result     owed_results [$];
        logic [1:0]  last_status;
        int          errors;
        int          checked;

        function new();
            foreach (arena[i]) arena[i] = 8'h00;
            wr_ptr      = 0;
            wr_left     = 0;
            last_status = STAT_OK;
            errors      = 0;
            checked     = 0;
        endfunction

        // Bytes past the arena end read as zero.
        function int unsigned byte_at(int unsigned i);
            return (i < ARENA_SIZE) ? 32'(arena[i]) : 0;
        endfunction

        // Walks record headers from start until one carries the tag.
        function bit walk(int unsigned start, bit [7:0] tg, output int unsigned found);
            int unsigned cur;
            cur   = start;
            found = 0;
            while (cur < ARENA_SIZE) begin
                if (arena[cur] == tg) begin
                    found = cur;
                    return 1'b1;
                end
                if (cur + 2 + byte_at(cur + 1) > ARENA_SIZE) return 1'b0;
                cur = cur + 2 + byte_at(cur + 1);
            end
            return 1'b0;
        endfunction

        // Picks one of the records chained from offset 0, if there is any.
        function bit pick_record(output int unsigned off, output bit [7:0] tg);
            int unsigned cur;
            int unsigned seen [$];
            cur = 0;
            off = 0;
            tg  = 8'h00;
            while (cur < ARENA_SIZE && arena[cur] != 8'h00) begin
                seen.push_back(cur);
                if (cur + 2 + byte_at(cur + 1) > ARENA_SIZE) break;
                cur = cur + 2 + byte_at(cur + 1);
            end
            if (seen.size() == 0) return 1'b0;
            off = seen[$urandom_range(0, seen.size() - 1)];
            tg  = arena[off];
            return 1'b1;
        endfunction

        function t_result make_res(logic [1:0] st, int unsigned ro, int unsigned rl,
                                   int unsigned nxt, bit nv, int unsigned rdat);
            t_result r;
            r.status        = st;
            r.record_offset = 10'(ro);
            r.record_length = 8'(rl);
            r.next_offset   = 10'(nxt);
            r.next_valid    = nv;
            r.read_data     = 8'(rdat);
            return r;
        endfunction

        // Applies one command beat to the arena and returns the result it causes.
        function t_result predict_result(t_cmd c);
            int unsigned at, nxt, rl, sz, pos, len;
            bit          placed;
            t_result     res;
            res = make_res(STAT_BAD, 0, 0, 0, 1'b0, 0);
            pos = 32'(c.position);
            len = 32'(c.length);
            at  = 0;
            case (c.operation)
                OP_FIND: begin
                    at = (c.use_position && pos < ARENA_SIZE) ? pos : 0;
                    if (!walk(at, c.tag, at)) begin
                        res = make_res(STAT_NOT_FOUND, 0, 0, 0, 1'b0, 0);
                    end else if (c.tag == 8'h00) begin
                        res = make_res(STAT_OK, at, 0, at, 1'b1, 0);
                    end else begin
                        rl  = byte_at(at + 1);
                        nxt = at + 2 + rl;
                        res = make_res(STAT_OK, at, rl, nxt, nxt < ARENA_SIZE, 0);
                    end
                end
                OP_WR_START: begin
                    placed = 1'b0;
                    if (c.use_position) begin
                        placed = (pos < ARENA_SIZE);
                        at     = pos;
                    end else if (walk(0, 8'h00, at)) begin
                        placed = 1'b1;
                    end else begin
                        res = make_res(STAT_NO_SPACE, 0, 0, 0, 1'b0, 0);
                    end
                    // The header bytes count toward the fit.
                    if (placed && at + 2 + len > ARENA_SIZE) begin
                        placed = 1'b0;
                        res    = make_res(STAT_NO_SPACE, 0, 0, 0, 1'b0, 0);
                    end
                    if (placed) begin
                        arena[at]     = c.tag;
                        arena[at + 1] = c.length;
                        wr_ptr        = at + 2;
                        wr_left       = len;
                        nxt           = at + 2 + len;
                        res = make_res(STAT_OK, at, len, nxt, nxt < ARENA_SIZE, 0);
                    end
                end
                OP_WR_DATA: begin
                    if (wr_left != 0 && wr_ptr < ARENA_SIZE) begin
                        at        = wr_ptr;
                        arena[at] = c.data_byte;
                        wr_ptr    = at + 1;
                        wr_left   = wr_left - 1;
                        res = make_res(STAT_OK, at, wr_left, wr_ptr, wr_ptr < ARENA_SIZE, 0);
                    end
                end
                OP_READ: begin
                    if (pos < ARENA_SIZE) res = make_res(STAT_OK, pos, 0, 0, 1'b0, arena[pos]);
                end
                OP_DELETE: begin
                    // Move everything behind the record down; the tail fills with zeros.
                    if (pos < ARENA_SIZE) begin
                        rl = byte_at(pos + 1);
                        sz = rl + 2;
                        for (int unsigned i = pos; i < ARENA_SIZE; i++) begin
                            arena[i] = 8'(byte_at(i + sz));
                        end
                        res = make_res(STAT_OK, pos, rl, 0, 1'b0, 0);
                    end
                end
                default: begin
                end
            endcase
            return res;
        endfunction

        function void note_command(t_cmd c);
            t_result res;
            res = predict_result(c);
            owed_results.push_back(res);
            last_status = res.status;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("tb: mismatch in %s at result %0d: got %0h, expected %0h",
                     what, checked, got, want);
        endtask

        // Compares one delivered result beat with the oldest owed one.
        task check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                report("unexpected result beat", 32'(got), 0);
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.record_offset !== want.record_offset)
                report("record_offset", 32'(got.record_offset), 32'(want.record_offset));
            if (got.record_length !== want.record_length)
                report("record_length", 32'(got.record_length), 32'(want.record_length));
            if (got.next_offset !== want.next_offset)
                report("next_offset", 32'(got.next_offset), 32'(want.next_offset));
            if (got.next_valid !== want.next_valid)
                report("next_valid", 32'(got.next_valid), 32'(want.next_valid));
            if (got.read_data !== want.read_data)
                report("read_data", 32'(got.read_data), 32'(want.read_data));
            checked++;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_operation;
    logic [7:0] i_tag;
    logic [7:0] i_length;
    logic [9:0] i_position;
    logic       i_use_position;
    logic [7:0] i_data_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_status;
    logic [9:0] o_record_offset;
    logic [7:0] o_record_length;
    logic [9:0] o_next_offset;
    logic       o_next_valid;
    logic [7:0] o_read_data;

    record_store_scoreboard sb;
    int send_idle_pct = 20;
    int recv_idle_pct = 71;
    int hold_request  = 0;
    int items_sent    = 0;

    tlv_record_store_top #(
        .ARENA_BYTES(ARENA)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_tag          (i_tag),
        .i_length       (i_length),
        .i_position     (i_position),
        .i_use_position (i_use_position),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_record_offset(o_record_offset),
        .o_record_length(o_record_length),
        .o_next_offset  (o_next_offset),
        .o_next_valid   (o_next_valid),
        .o_read_data    (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest legal schedule.
    initial begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic t_cmd make_cmd(logic [2:0] op, logic [7:0] tg, logic [7:0] len,
                                      logic [9:0] pos, logic usep, logic [7:0] db);
        t_cmd c;
        c.operation    = op;
        c.tag          = tg;
        c.length       = len;
        c.position     = pos;
        c.use_position = usep;
        c.data_byte    = db;
        return c;
    endfunction

    // Offers one command beat, with a random gap first, and holds it until taken.
    task automatic send_beat(input t_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= c.operation;
        i_tag          <= c.tag;
        i_length       <= c.length;
        i_position     <= c.position;
        i_use_position <= c.use_position;
        i_data_byte    <= c.data_byte;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_command(c);
        items_sent++;
    endtask

    // Header beat, then payload beats if the header was placed.
    task automatic write_record(input bit [7:0] tg, input int unsigned len, input bit usep,
                                input int unsigned pos, input int unsigned beats);
        send_beat(make_cmd(OP_WR_START, tg, 8'(len), 10'(pos), usep, 8'($urandom)));
        if (sb.last_status == STAT_OK) begin
            repeat (beats) begin
                send_beat(make_cmd(OP_WR_DATA, 8'($urandom), 8'($urandom), 10'($urandom),
                                   1'($urandom), 8'($urandom)));
            end
        end
    endtask

    // Result side: checks each delivered beat and paces the ready signal.
    initial begin
        int     hold_left;
        t_result got;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                got.status        = o_status;
                got.record_offset = o_record_offset;
                got.record_length = o_record_length;
                got.next_offset   = o_next_offset;
                got.next_valid    = o_next_valid;
                got.read_data     = o_read_data;
                sb.check_result(got);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Command side: reset, directed beats, then random traffic.
    initial begin
        int unsigned r, fe, off, len, beats, pos;
        bit [7:0]    tg;
        bit          have_rec, have_empty, usep, hold_done, pause_done;
        int          wait_cycles;

        sb             = new();
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_operation    <= OP_FIND;
        i_tag          <= 8'h00;
        i_length       <= 8'h00;
        i_position     <= 10'd0;
        i_use_position <= 1'b0;
        i_data_byte    <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty arena: a missing tag walks to the end, the empty tag hits at once.
        send_beat(make_cmd(OP_FIND, 8'h05, 8'hFF, 10'd0, 1'b0, 8'h00));
        send_beat(make_cmd(OP_FIND, 8'h00, 8'h00, 10'd700, 1'b1, 8'hFF));
        // Payload byte with no record open, then a full record and one byte too many.
        send_beat(make_cmd(OP_WR_DATA, 8'h00, 8'h00, 10'd0, 1'b0, 8'hFF));
        write_record(8'hAA, 3, 1'b0, 0, 3);
        send_beat(make_cmd(OP_WR_DATA, 8'hAA, 8'h00, 10'h3FF, 1'b1, 8'h00));
        send_beat(make_cmd(OP_FIND, 8'hAA, 8'h00, 10'd0, 1'b0, 8'h00));
        send_beat(make_cmd(OP_READ, 8'h00, 8'h00, 10'd3, 1'b0, 8'h00));
        send_beat(make_cmd(OP_READ, 8'hFF, 8'hFF, 10'h3FF, 1'b1, 8'hFF));
        // A record that ends exactly at the arena end, then one byte too long there.
        write_record(8'h01, 2, 1'b1, ARENA - 4, 2);
        write_record(8'h02, 3, 1'b1, ARENA - 4, 0);
        // Largest payload, abandoned after two bytes by a fresh header.
        write_record(8'hFF, 255, 1'b0, 0, 2);
        write_record(8'h11, 0, 1'b0, 0, 0);
        // A length byte that points past the arena end stops the walk.
        write_record(8'h44, 5, 1'b1, 999, 0);
        send_beat(make_cmd(OP_WR_DATA, 8'h00, 8'h00, 10'd0, 1'b0, 8'hF0));
        send_beat(make_cmd(OP_FIND, 8'h77, 8'h00, 10'd1000, 1'b1, 8'h00));
        send_beat(make_cmd(OP_FIND, 8'h11, 8'h80, 10'h3FF, 1'b1, 8'h00));
        // Deletes at the first and the last byte, then the unused operation codes.
        send_beat(make_cmd(OP_DELETE, 8'h00, 8'h00, 10'd0, 1'b0, 8'h00));
        send_beat(make_cmd(OP_DELETE, 8'hFF, 8'hFF, 10'h3FF, 1'b1, 8'hFF));
        for (int k = 5; k < 8; k++) begin
            send_beat(make_cmd(3'(k), 8'hFF, 8'hFF, 10'h3FF, 1'b1, 8'hFF));
        end

        while (items_sent < ITEMS_TOTAL) begin
            if (items_sent >= 2 * ITEMS_TOTAL / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= ITEMS_TOTAL / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 20;
            end
            // Long receiver stall while commands keep coming: the block backs up.
            if (!hold_done && items_sent >= 120) begin
                hold_request = 400;
                hold_done    = 1'b1;
            end
            // Quiet point: nothing offered until every owed result has come out.
            if (!pause_done && items_sent >= 300) begin
                i_in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end

            fe         = 0;
            r          = $urandom_range(0, 99);
            have_rec   = sb.pick_record(off, tg);
            have_empty = sb.walk(0, 8'h00, fe);
            // A crowded arena gets deletes instead of more records.
            if ((!have_empty || fe > 700) && r < 45) r = 85;

            if (r < 45) begin
                // Well-formed record with random content, now and then cut short.
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(41, 255);
                    1, 2:    len = $urandom_range(11, 40);
                    default: len = $urandom_range(0, 10);
                endcase
                tg    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
                usep  = ($urandom_range(0, 7) == 0);
                pos   = (have_empty && $urandom_range(0, 1) == 1) ? fe
                                                                  : $urandom_range(0, ARENA - 1);
                beats = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
                write_record(tg, len, usep, pos, beats);
            end else if (r < 65) begin
                // Lookup of a stored tag or a random one, from the start or mid-arena.
                if (!have_rec || $urandom_range(0, 2) == 0) tg = 8'($urandom);
                usep = ($urandom_range(0, 2) == 0);
                pos  = (have_rec && $urandom_range(0, 1) == 1) ? off
                                                               : $urandom_range(0, ARENA - 1);
                send_beat(make_cmd(OP_FIND, tg, 8'($urandom), 10'(pos), usep, 8'($urandom)));
            end else if (r < 78) begin
                send_beat(make_cmd(OP_READ, 8'($urandom), 8'($urandom),
                                   10'($urandom_range(0, ARENA - 1)), 1'($urandom),
                                   8'($urandom)));
            end else if (r < 81) begin
                // Stray payload byte: extends an open record or is refused.
                send_beat(make_cmd(OP_WR_DATA, 8'($urandom), 8'($urandom), 10'($urandom),
                                   1'($urandom), 8'($urandom)));
            end else if (r < 93) begin
                pos = (have_rec && $urandom_range(0, 3) != 0) ? off
                                                              : $urandom_range(0, ARENA - 1);
                send_beat(make_cmd(OP_DELETE, 8'($urandom), 8'($urandom), 10'(pos),
                                   1'($urandom), 8'($urandom)));
            end else if (r < 97) begin
                send_beat(make_cmd(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                                   10'($urandom), 1'($urandom), 8'($urandom)));
            end else begin
                send_beat(make_cmd(OP_FIND, 8'h00, 8'($urandom), 10'($urandom),
                                   1'($urandom), 8'($urandom)));
            end
        end

        // Drain: every owed result must come out, then a short quiet tail.
        i_in_valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 200000 && sb.pending() != 0; wait_cycles++) begin
            @(posedge i_clk);
        end
        if (sb.pending() != 0) sb.report("results never delivered", sb.pending(), 0);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tlvrs_pkg.sv
sv/tlvrs_ram.sv
sv/tlvrs_engine.sv
sv/tlv_record_store_top.sv
tb/sv/tb.sv
